### rtl/core/qse_pkg.sv
// shared types and constants of the quaternion smoothing and euler unit
// angle units, cordic arctangent table, request structs of the serial units
`timescale 1ns / 1ps

package qse_pkg;

    localparam int MUL_W    = 32;
    localparam int PROD_W   = 64;
    localparam int DIGIT_W  = 4;
    localparam int ANG_W    = 25;
    localparam int ATAN_LEN = 24;

    // angles in 1/256 of 0.01 degree
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 25'sd4608000;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 25'sd2304000;

    typedef struct packed {
        logic                    start;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                    start;
        logic signed [MUL_W-1:0] y;
        logic signed [MUL_W-1:0] x;
    } t_cor_req;

    function automatic logic [20:0] atan_step(input logic [4:0] idx);
        logic [20:0] v;
        case (idx)
            5'd0:    v = 21'd1152000;
            5'd1:    v = 21'd680065;
            5'd2:    v = 21'd359328;
            5'd3:    v = 21'd182400;
            5'd4:    v = 21'd91554;
            5'd5:    v = 21'd45822;
            5'd6:    v = 21'd22916;
            5'd7:    v = 21'd11459;
            5'd8:    v = 21'd5730;
            5'd9:    v = 21'd2865;
            5'd10:   v = 21'd1432;
            5'd11:   v = 21'd716;
            5'd12:   v = 21'd358;
            5'd13:   v = 21'd179;
            5'd14:   v = 21'd90;
            5'd15:   v = 21'd45;
            5'd16:   v = 21'd22;
            5'd17:   v = 21'd11;
            5'd18:   v = 21'd6;
            5'd19:   v = 21'd3;
            5'd20:   v = 21'd1;
            5'd21:   v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/qse_mul.sv
// digit-serial signed multiplier, 32 x 32 -> 64, one 4-bit digit per cycle
// depends on qse_pkg
`timescale 1ns / 1ps

module qse_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  qse_pkg::t_mul_req                 i_req,
    output logic                              o_done,
    output logic signed [qse_pkg::PROD_W-1:0] o_prod
);
    import qse_pkg::*;

    localparam int NDIG = MUL_W / DIGIT_W;
    localparam int CW   = $clog2(NDIG);
    localparam logic [CW-1:0] LAST = CW'(NDIG - 1);

    logic                     r_busy;
    logic                     r_done;
    logic [CW-1:0]            r_cnt;
    logic signed [PROD_W-1:0] r_mcand;
    logic [MUL_W-1:0]         r_mplier;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [DIGIT_W:0]  w_digit;
    logic signed [PROD_W-1:0] w_pp;

    // top digit carries the sign of the multiplier
    assign w_digit = (r_cnt == LAST) ? {r_mplier[DIGIT_W-1], r_mplier[DIGIT_W-1:0]}
                                     : {1'b0, r_mplier[DIGIT_W-1:0]};
    assign w_pp = r_mcand * $signed({{(PROD_W-DIGIT_W-1){w_digit[DIGIT_W]}}, w_digit});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_mcand  <= PROD_W'(i_req.a);
                r_mplier <= i_req.b;
                r_acc    <= '0;
            end else if (r_busy) begin
                r_acc    <= r_acc + w_pp;
                r_mcand  <= r_mcand <<< DIGIT_W;
                r_mplier <= r_mplier >> DIGIT_W;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### rtl/core/qse_cordic.sv
// iterative vectoring cordic, atan2(y, x) in 1/256 centidegree, one step a cycle
// depends on qse_pkg
`timescale 1ns / 1ps

module qse_cordic #(
    parameter int STEPS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  qse_pkg::t_cor_req                i_req,
    output logic                             o_done,
    output logic signed [qse_pkg::ANG_W-1:0] o_angle
);
    import qse_pkg::*;

    localparam int CW = MUL_W + 3;
    localparam int IW = $clog2(STEPS);
    localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

    logic                    r_busy;
    logic                    r_done;
    logic [IW-1:0]           r_i;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [ANG_W-1:0] r_z;
    logic signed [CW-1:0]    w_xin;
    logic signed [CW-1:0]    w_yin;
    logic signed [CW-1:0]    w_xs;
    logic signed [CW-1:0]    w_ys;
    logic signed [ANG_W-1:0] w_at;

    assign w_xin = CW'(i_req.x);
    assign w_yin = CW'(i_req.y);
    assign w_xs  = r_x >>> r_i;
    assign w_ys  = r_y >>> r_i;
    assign w_at  = $signed({{(ANG_W-21){1'b0}}, atan_step(5'(r_i))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_i <= '0;
                if (w_xin == '0 && w_yin == '0) begin
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    if (w_xin < 0) begin
                        // left half plane: rotate by half a turn first
                        r_x <= -w_xin;
                        r_y <= -w_yin;
                        r_z <= (w_yin >= 0) ? HALF_TURN : -HALF_TURN;
                    end else begin
                        r_x <= w_xin;
                        r_y <= w_yin;
                        r_z <= '0;
                    end
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_z > HALF_TURN) begin
            o_angle = HALF_TURN;
        end else if (r_z < -HALF_TURN) begin
            o_angle = -HALF_TURN;
        end else begin
            o_angle = r_z;
        end
    end

    assign o_done = r_done;

endmodule

### rtl/core/quaternion_smooth_to_euler_unit.sv
// top level: quaternion smoothing, euler conversion and angle smoothing
// depends on qse_pkg, qse_mul, qse_cordic
//
// usage:
//   input channel i_valid/o_ready carries one imu sample per item with a
//   sample-valid flag; output channel o_valid/i_ready returns one result item
//   per input item: connected flag, smoothed quaternion, smoothed roll, pitch
//   and yaw in 0.01 deg, and the item count.
//   config channel i_cfg_valid/o_cfg_ready writes smoothing_alpha; write it
//   only while no item is in flight.
//   a valid sample runs a fixed sequence on one 4-bit digit-serial multiplier
//   (18 products), a bit-serial square root and an iterative cordic (three
//   runs). a sample past the pitch poles skips one product, the square root
//   and one cordic run. an invalid sample skips the sequence. one item is
//   worked on at a time.
//   the result sits in an output register; the next item is accepted while
//   it waits, and a finished item holds until the register frees up.
//   reset (synchronous, active low) sets alpha to 19661, the averages to the
//   identity orientation, link down and the count to zero.
`timescale 1ns / 1ps

module quaternion_smooth_to_euler_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_smoothing_alpha,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_sample_valid,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_connected,
    output logic signed [15:0] o_smooth_w,
    output logic signed [15:0] o_smooth_x,
    output logic signed [15:0] o_smooth_y,
    output logic signed [15:0] o_smooth_z,
    output logic signed [15:0] o_roll_cdeg,
    output logic signed [14:0] o_pitch_cdeg,
    output logic signed [15:0] o_yaw_cdeg,
    output logic [31:0]        o_frame_number
);
    import qse_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_MULW  = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_CORW  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [4:0] OP_EMA_W   = 5'd0;
    localparam logic [4:0] OP_EMA_X   = 5'd1;
    localparam logic [4:0] OP_EMA_Y   = 5'd2;
    localparam logic [4:0] OP_EMA_Z   = 5'd3;
    localparam logic [4:0] OP_WX      = 5'd4;
    localparam logic [4:0] OP_YZ      = 5'd5;
    localparam logic [4:0] OP_XX      = 5'd6;
    localparam logic [4:0] OP_YY      = 5'd7;
    localparam logic [4:0] OP_ROLL    = 5'd8;
    localparam logic [4:0] OP_WY      = 5'd9;
    localparam logic [4:0] OP_ZX      = 5'd10;
    localparam logic [4:0] OP_PCHK    = 5'd11;
    localparam logic [4:0] OP_SS      = 5'd12;
    localparam logic [4:0] OP_SQRT    = 5'd13;
    localparam logic [4:0] OP_PITCH   = 5'd14;
    localparam logic [4:0] OP_WZ      = 5'd15;
    localparam logic [4:0] OP_XY      = 5'd16;
    localparam logic [4:0] OP_YY2     = 5'd17;
    localparam logic [4:0] OP_ZZ      = 5'd18;
    localparam logic [4:0] OP_YAW     = 5'd19;
    localparam logic [4:0] OP_EMA_R   = 5'd20;
    localparam logic [4:0] OP_EMA_P   = 5'd21;
    localparam logic [4:0] OP_EMA_YW  = 5'd22;
    localparam logic [4:0] OP_FINISH  = 5'd23;

    localparam logic [15:0] ALPHA_RESET = 16'd19661;
    localparam logic signed [23:0] ONE_Q22 = 24'sd4194304;
    localparam logic signed [63:0] ONE_Q44 = 64'sd17592186044416;
    localparam logic signed [63:0] POLE    = 64'sd8796093022208;
    localparam logic [61:0] SQ_ONE = 62'd1152921504606846976;
    localparam logic [61:0] SQ_TOP = 62'd1152921504606846976;

    logic [2:0]               r_state;
    logic [4:0]               r_pc;
    logic [15:0]              r_alpha;
    logic signed [23:0]       r_avg [7];
    logic signed [15:0]       r_q [4];
    logic signed [ANG_W-1:0]  r_ang [3];
    logic                     r_link;
    logic [31:0]              r_count;
    logic signed [63:0]       r_acc0;
    logic signed [63:0]       r_acc1;
    logic signed [31:0]       r_s;
    logic [61:0]              r_sv;
    logic [61:0]              r_sr;
    logic [61:0]              r_sbit;
    logic                     r_ovalid;
    logic                     r_oconn;
    logic signed [15:0]       r_osq [4];
    logic signed [15:0]       r_oroll;
    logic signed [14:0]       r_opitch;
    logic signed [15:0]       r_oyaw;
    logic [31:0]              r_oframe;

    t_mul_req                 w_mul_req;
    t_cor_req                 w_cor_req;
    logic                     w_mul_done;
    logic signed [PROD_W-1:0] w_prod;
    logic                     w_cor_done;
    logic signed [ANG_W-1:0]  w_cor_ang;
    logic [2:0]               w_k;
    logic                     w_is_mul;
    logic                     w_is_cor;
    logic signed [23:0]       w_ema_avg;
    logic signed [23:0]       w_ema_tgt;
    logic signed [31:0]       w_diff;
    logic signed [63:0]       w_rnd;
    logic signed [27:0]       w_sum;
    logic signed [23:0]       w_ema_new;
    logic signed [63:0]       w_cos_q44;
    logic signed [31:0]       w_y20;
    logic signed [31:0]       w_x20;
    logic [61:0]              w_strial;
    logic                     w_load;

    function automatic logic signed [31:0] sx(input logic signed [23:0] v);
        return 32'(v);
    endfunction

    function automatic logic signed [15:0] cdeg(input logic signed [23:0] v);
        logic signed [24:0] t;
        t = 25'(v) + 25'sd128;
        return t[23:8];
    endfunction

    qse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    qse_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cor_req),
        .o_done  (w_cor_done),
        .o_angle (w_cor_ang)
    );

    // roll and yaw operands, both from the two accumulators
    assign w_cos_q44 = ONE_Q44 - (r_acc1 <<< 1);
    assign w_y20     = 32'(r_acc0 >>> 19);
    assign w_x20     = 32'(w_cos_q44 >>> 20);

    // average slot of the ema ops
    always_comb begin
        case (r_pc)
            OP_EMA_W:  w_k = 3'd0;
            OP_EMA_X:  w_k = 3'd1;
            OP_EMA_Y:  w_k = 3'd2;
            OP_EMA_Z:  w_k = 3'd3;
            OP_EMA_R:  w_k = 3'd4;
            OP_EMA_P:  w_k = 3'd5;
            default:   w_k = 3'd6;
        endcase
    end

    assign w_ema_avg = r_avg[w_k];
    assign w_ema_tgt = (w_k[2] == 1'b0) ? {r_q[w_k[1:0]], 8'd0}
                                        : 24'(r_ang[2'(w_k - 3'd4)]);
    assign w_diff    = sx(w_ema_tgt) - sx(w_ema_avg);
    assign w_rnd     = (w_prod + 64'sd32768) >>> 16;
    assign w_sum     = w_rnd[27:0] + 28'(w_ema_avg);

    always_comb begin
        if (w_sum > 28'sd8388607) begin
            w_ema_new = 24'sd8388607;
        end else if (w_sum < -28'sd8388608) begin
            w_ema_new = -24'sd8388608;
        end else begin
            w_ema_new = w_sum[23:0];
        end
    end

    // operand selection for the shared units
    always_comb begin
        w_is_mul    = 1'b0;
        w_is_cor    = 1'b0;
        w_mul_req.a = '0;
        w_mul_req.b = '0;
        w_cor_req.y = '0;
        w_cor_req.x = '0;
        unique case (r_pc)
            OP_EMA_W, OP_EMA_X, OP_EMA_Y, OP_EMA_Z, OP_EMA_R, OP_EMA_P, OP_EMA_YW: begin
                w_is_mul    = 1'b1;
                w_mul_req.a = w_diff;
                w_mul_req.b = {16'd0, r_alpha};
            end
            OP_WX: begin
                w_is_mul = 1'b1; w_mul_req.a = sx(r_avg[0]); w_mul_req.b = sx(r_avg[1]);
            end
            OP_YZ: begin
                w_is_mul = 1'b1; w_mul_req.a = sx(r_avg[2]); w_mul_req.b = sx(r_avg[3]);
            end
            OP_XX: begin
                w_is_mul = 1'b1; w_mul_req.a = sx(r_avg[1]); w_mul_req.b = sx(r_avg[1]);
            end
            OP_YY, OP_YY2: begin
                w_is_mul = 1'b1; w_mul_req.a = sx(r_avg[2]); w_mul_req.b = sx(r_avg[2]);
            end
            OP_WY: begin
                w_is_mul = 1'b1; w_mul_req.a = sx(r_avg[0]); w_mul_req.b = sx(r_avg[2]);
            end
            OP_ZX: begin
                w_is_mul = 1'b1; w_mul_req.a = sx(r_avg[3]); w_mul_req.b = sx(r_avg[1]);
            end
            OP_SS: begin
                w_is_mul = 1'b1; w_mul_req.a = r_s; w_mul_req.b = r_s;
            end
            OP_WZ: begin
                w_is_mul = 1'b1; w_mul_req.a = sx(r_avg[0]); w_mul_req.b = sx(r_avg[3]);
            end
            OP_XY: begin
                w_is_mul = 1'b1; w_mul_req.a = sx(r_avg[1]); w_mul_req.b = sx(r_avg[2]);
            end
            OP_ZZ: begin
                w_is_mul = 1'b1; w_mul_req.a = sx(r_avg[3]); w_mul_req.b = sx(r_avg[3]);
            end
            OP_ROLL, OP_YAW: begin
                w_is_cor    = 1'b1;
                w_cor_req.y = w_y20;
                w_cor_req.x = w_x20;
            end
            OP_PITCH: begin
                w_is_cor    = 1'b1;
                w_cor_req.y = r_s;
                w_cor_req.x = {1'b0, r_sr[30:0]};
            end
            default: begin
            end
        endcase
        w_mul_req.start = (r_state == ST_ISSUE) && w_is_mul;
        w_cor_req.start = (r_state == ST_ISSUE) && w_is_cor;
    end

    assign w_strial = r_sr + r_sbit;
    assign w_load   = (r_state == ST_DONE) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= OP_EMA_W;
            r_alpha  <= ALPHA_RESET;
            r_avg[0] <= ONE_Q22;
            r_avg[1] <= '0;
            r_avg[2] <= '0;
            r_avg[3] <= '0;
            r_avg[4] <= '0;
            r_avg[5] <= '0;
            r_avg[6] <= '0;
            r_link   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_alpha <= i_smoothing_alpha;
            end

            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_count <= r_count + 1'b1;
                        r_link  <= i_sample_valid;
                        r_pc    <= OP_EMA_W;
                        r_q[0]  <= i_quat_w;
                        r_q[1]  <= i_quat_x;
                        r_q[2]  <= i_quat_y;
                        r_q[3]  <= i_quat_z;
                        r_state <= i_sample_valid ? ST_ISSUE : ST_DONE;
                    end
                end
                ST_ISSUE: begin
                    if (w_is_mul) begin
                        r_state <= ST_MULW;
                    end else if (w_is_cor) begin
                        r_state <= ST_CORW;
                    end else if (r_pc == OP_PCHK) begin
                        // pitch saturates at the poles
                        if (r_acc0 >= POLE) begin
                            r_ang[1] <= QUARTER_TURN;
                            r_pc     <= OP_WZ;
                        end else if (r_acc0 <= -POLE) begin
                            r_ang[1] <= -QUARTER_TURN;
                            r_pc     <= OP_WZ;
                        end else begin
                            r_s  <= 32'(r_acc0 >>> 13);
                            r_pc <= r_pc + 1'b1;
                        end
                    end else if (r_pc == OP_SQRT) begin
                        r_sv    <= SQ_ONE - r_acc1[61:0];
                        r_sr    <= '0;
                        r_sbit  <= SQ_TOP;
                        r_state <= ST_SQRT;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_MULW: begin
                    if (w_mul_done) begin
                        case (r_pc)
                            OP_WX, OP_WY, OP_WZ: r_acc0 <= w_prod;
                            OP_YZ, OP_XY:        r_acc0 <= r_acc0 + w_prod;
                            OP_ZX:               r_acc0 <= r_acc0 - w_prod;
                            OP_XX, OP_SS, OP_YY2: r_acc1 <= w_prod;
                            OP_YY, OP_ZZ:        r_acc1 <= r_acc1 + w_prod;
                            default:             r_avg[w_k] <= w_ema_new;
                        endcase
                        r_pc    <= r_pc + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_SQRT: begin
                    // one root bit a cycle
                    if (r_sv >= w_strial) begin
                        r_sv <= r_sv - w_strial;
                        r_sr <= (r_sr >> 1) + r_sbit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit[0]) begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_CORW: begin
                    if (w_cor_done) begin
                        case (r_pc)
                            OP_ROLL: r_ang[0] <= w_cor_ang;
                            OP_PITCH: begin
                                if (w_cor_ang > QUARTER_TURN) begin
                                    r_ang[1] <= QUARTER_TURN;
                                end else if (w_cor_ang < -QUARTER_TURN) begin
                                    r_ang[1] <= -QUARTER_TURN;
                                end else begin
                                    r_ang[1] <= w_cor_ang;
                                end
                            end
                            default: r_ang[2] <= w_cor_ang;
                        endcase
                        r_pc    <= r_pc + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oconn  <= r_link;
            r_osq[0] <= r_avg[0][23:8];
            r_osq[1] <= r_avg[1][23:8];
            r_osq[2] <= r_avg[2][23:8];
            r_osq[3] <= r_avg[3][23:8];
            r_oroll  <= cdeg(r_avg[4]);
            r_opitch <= 15'(cdeg(r_avg[5]));
            r_oyaw   <= cdeg(r_avg[6]);
            r_oframe <= r_count;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_ovalid;
    assign o_connected    = r_oconn;
    assign o_smooth_w     = r_osq[0];
    assign o_smooth_x     = r_osq[1];
    assign o_smooth_y     = r_osq[2];
    assign o_smooth_z     = r_osq[3];
    assign o_roll_cdeg    = r_oroll;
    assign o_pitch_cdeg   = r_opitch;
    assign o_yaw_cdeg     = r_oyaw;
    assign o_frame_number = r_oframe;

endmodule
